// File: rtl/core/bcd_pkg.sv
package bcd_pkg;

  // Fixed widths of the port fields and of the counters.
  localparam int PIN_W   = 20;
  localparam int LV_W    = 32;
  localparam int CNT_W   = 16;
  localparam int PINIX_W = 5;
  localparam int ADDR_W  = 3;

  // Register indexes on the configuration port.
  typedef enum logic [ADDR_W-1:0] {
    REG_MODE         = 3'd0,
    REG_LONG_PRESS   = 3'd1,
    REG_CLICK_WINDOW = 3'd2,
    REG_RESET_HOLD   = 3'd3,
    REG_IDLE_STOP    = 3'd4,
    REG_FIRST_PIN    = 3'd5,
    REG_SECOND_PIN   = 3'd6,
    REG_RESET_MASK   = 3'd7
  } reg_idx_t;

  // Button operating modes.
  typedef enum logic [1:0] {
    MODE_TOGGLE    = 2'd0,
    MODE_MOMENTARY = 2'd1,
    MODE_MULTI     = 2'd2,
    MODE_OFF       = 2'd3
  } mode_t;

  // Event codes reported per button.
  typedef enum logic [3:0] {
    EV_NONE         = 4'd0,
    EV_TOGGLE       = 4'd1,
    EV_PRESSED      = 4'd2,
    EV_RELEASED     = 4'd3,
    EV_SINGLE       = 4'd4,
    EV_DOUBLE       = 4'd5,
    EV_TRIPLE       = 4'd6,
    EV_LONG_PRESS   = 4'd7,
    EV_LONG_RELEASE = 4'd8
  } evt_t;

  // Click tracking state of one button.
  typedef enum logic [4:0] {
    CS_IDLE   = 5'b00001,
    CS_SINGLE = 5'b00010,
    CS_DOUBLE = 5'b00100,
    CS_TRIPLE = 5'b01000,
    CS_LONG   = 5'b10000
  } click_st_t;

  // What one button lane found on this tick.
  typedef struct packed {
    evt_t ev;
    logic pressed;
    logic blink;
  } lane_res_t;

  // What the reset combination lane found on this tick.
  typedef struct packed {
    logic fire;
    logic pressed;
    logic blink;
  } hold_res_t;

  // One result word as it leaves the block.
  typedef struct packed {
    logic [3:0] first_event;
    logic [3:0] second_event;
    logic       reset_event;
    logic [2:0] blink_request;
    logic       any_pressed;
    logic       stop_scan;
  } word_t;

  // Event code that a finished click count reports.
  function automatic evt_t click_code(input click_st_t cs);
    evt_t ev;
    case (cs)
      CS_SINGLE: ev = EV_SINGLE;
      CS_DOUBLE: ev = EV_DOUBLE;
      CS_TRIPLE: ev = EV_TRIPLE;
      default:   ev = EV_NONE;
    endcase
    return ev;
  endfunction

endpackage

// File: rtl/core/bcd_lane.sv
module bcd_lane import bcd_pkg::*; #(
  parameter int DEBOUNCE_BITS = 4,
  parameter int NUM_PINS      = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               clr,
  input  mode_t              mode,
  input  logic [CNT_W-1:0]   long_ticks,
  input  logic [CNT_W-1:0]   window_ticks,
  input  logic [LV_W-1:0]    levels,
  input  logic [PINIX_W-1:0] pin,
  output lane_res_t          res
);

  logic [DEBOUNCE_BITS-1:0] hist_r, hist_nxt;
  logic                     pressed_r, pressed_nxt;
  logic [CNT_W-1:0]         tick_r, tick_nxt;
  click_st_t                cs_r, cs_nxt;

  logic                     up;
  logic [DEBOUNCE_BITS:0]   shifted;
  logic                     all0, all1;
  logic [CNT_W-1:0]         t_inc, t1;
  click_st_t                cs_up;
  evt_t                     ev;

  // A pin beyond the populated range reads as released.
  assign up      = ({1'b0, pin} < 6'(NUM_PINS)) ? levels[pin] : 1'b1;
  assign shifted = {hist_r, up};
  assign t_inc   = (tick_r != '1) ? tick_r + 1'b1 : tick_r;

  // Debounce and per-mode event logic for one tick.
  always_comb begin
    hist_nxt    = shifted[DEBOUNCE_BITS-1:0];
    all0        = (hist_nxt == '0);
    all1        = &hist_nxt;
    pressed_nxt = pressed_r;
    tick_nxt    = tick_r;
    cs_nxt      = cs_r;
    cs_up       = cs_r;
    t1          = '0;
    ev          = EV_NONE;
    case (mode)
      MODE_TOGGLE, MODE_MOMENTARY: begin
        if (all0) begin
          if (!pressed_r) begin
            pressed_nxt = 1'b1;
            ev = (mode == MODE_TOGGLE) ? EV_TOGGLE : EV_PRESSED;
          end
        end else if (all1) begin
          if (pressed_r) begin
            pressed_nxt = 1'b0;
            cs_nxt      = CS_IDLE;
            tick_nxt    = '0;
            if (mode == MODE_MOMENTARY) begin
              ev = EV_RELEASED;
            end
          end
        end
      end
      MODE_MULTI: begin
        if (all0) begin
          // Held: count up, restarting at the press itself.
          pressed_nxt = 1'b1;
          t1          = pressed_r ? t_inc : '0;
          tick_nxt    = t1;
          case (cs_r)
            CS_IDLE: begin
              if (t1 == '0) begin
                cs_nxt = CS_SINGLE;
              end
            end
            CS_SINGLE, CS_DOUBLE, CS_TRIPLE: begin
              if (cs_r == CS_SINGLE && t1 == long_ticks) begin
                cs_nxt = CS_LONG;
                ev     = EV_LONG_PRESS;
              end else begin
                if (t1 == '0) begin
                  if (cs_r == CS_SINGLE) begin
                    cs_up = CS_DOUBLE;
                  end else if (cs_r == CS_DOUBLE) begin
                    cs_up = CS_TRIPLE;
                  end
                end
                cs_nxt = cs_up;
                if (t1 == window_ticks && cs_up != CS_SINGLE) begin
                  ev       = click_code(cs_up);
                  cs_nxt   = CS_IDLE;
                  tick_nxt = '0;
                end
              end
            end
            default: begin
              cs_nxt = cs_r;
            end
          endcase
        end else if (all1) begin
          // Released: count quiet ticks, restarting at the release.
          pressed_nxt = 1'b0;
          t1          = pressed_r ? '0 : t_inc;
          tick_nxt    = t1;
          case (cs_r)
            CS_SINGLE, CS_DOUBLE, CS_TRIPLE: begin
              if (t1 == window_ticks) begin
                ev       = click_code(cs_r);
                cs_nxt   = CS_IDLE;
                tick_nxt = '0;
              end
            end
            CS_LONG: begin
              ev       = EV_LONG_RELEASE;
              cs_nxt   = CS_IDLE;
              tick_nxt = '0;
            end
            default: begin
              cs_nxt = cs_r;
            end
          endcase
        end
      end
      default: begin
        pressed_nxt = pressed_r;
      end
    endcase
  end

  assign res.ev      = ev;
  assign res.pressed = pressed_nxt;
  assign res.blink   = !pressed_r && pressed_nxt;

  // Lane state; a mode write clears the click tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r    <= '1;
      pressed_r <= 1'b0;
      tick_r    <= '0;
      cs_r      <= CS_IDLE;
    end else begin
      if (step) begin
        hist_r    <= hist_nxt;
        pressed_r <= pressed_nxt;
        tick_r    <= tick_nxt;
        cs_r      <= cs_nxt;
      end
      if (clr) begin
        tick_r <= '0;
        cs_r   <= CS_IDLE;
      end
    end
  end

endmodule

// File: rtl/core/bcd_hold.sv
module bcd_hold import bcd_pkg::*; #(
  parameter int DEBOUNCE_BITS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [CNT_W-1:0] hold_ticks,
  input  logic [LV_W-1:0]  levels,
  input  logic [LV_W-1:0]  mask,
  output hold_res_t        res
);

  logic [DEBOUNCE_BITS-1:0] hist_r, hist_nxt;
  logic                     pressed_r, pressed_nxt;
  logic [CNT_W-1:0]         tick_r, tick_nxt;

  logic                     up;
  logic [DEBOUNCE_BITS:0]   shifted;
  logic                     all0, all1;
  logic [CNT_W-1:0]         t_inc;

  // Any high pin of the combination means it is released.
  assign up       = |(levels & mask);
  assign shifted  = {hist_r, up};
  assign hist_nxt = shifted[DEBOUNCE_BITS-1:0];
  assign all0     = (hist_nxt == '0);
  assign all1     = &hist_nxt;
  assign t_inc    = (tick_r != '1) ? tick_r + 1'b1 : tick_r;

  // Hold counting: the count is only cleared on release.
  always_comb begin
    pressed_nxt = pressed_r;
    tick_nxt    = tick_r;
    if (all0) begin
      pressed_nxt = 1'b1;
      tick_nxt    = t_inc;
    end else if (all1 && pressed_r) begin
      pressed_nxt = 1'b0;
      tick_nxt    = '0;
    end
  end

  // The event fires only when the count actually steps onto the limit.
  assign res.fire    = all0 && (tick_r != '1) && (t_inc == hold_ticks);
  assign res.pressed = pressed_nxt;
  assign res.blink   = !pressed_r && pressed_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r    <= '1;
      pressed_r <= 1'b0;
      tick_r    <= '0;
    end else if (step) begin
      hist_r    <= hist_nxt;
      pressed_r <= pressed_nxt;
      tick_r    <= tick_nxt;
    end
  end

endmodule

// File: rtl/core/bcd_merge.sv
module bcd_merge import bcd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lane_res_t        res0,
  input  lane_res_t        res1,
  input  hold_res_t        hres,
  input  logic [CNT_W-1:0] idle_stop_ticks,
  output logic             out_valid,
  input  logic             out_ready,
  output word_t            out_word
);

  logic [CNT_W-1:0] idle_r, idle_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  word_t            q0_r, q1_r;
  word_t            word_in;
  logic             push, pop, any, stop;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_word  = q0_r;

  // Combine the lanes and run the idle counter.
  assign any = res0.pressed || res1.pressed || hres.pressed;

  always_comb begin
    idle_nxt = any ? '0 : ((idle_r != '1) ? idle_r + 1'b1 : idle_r);
    stop     = (idle_nxt == idle_stop_ticks);
    if (stop) begin
      idle_nxt = '0;
    end
  end

  always_comb begin
    word_in.first_event   = res0.ev;
    word_in.second_event  = res1.ev;
    word_in.reset_event   = hres.fire;
    word_in.blink_request = {hres.blink, res1.blink, res0.blink};
    word_in.any_pressed   = any;
    word_in.stop_scan     = stop;
  end

  // Two-word output queue, so a word is taken while one waits.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt_r == 2'd2) begin
        q0_r <= q1_r;
      end else if (push) begin
        q0_r <= word_in;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        q0_r <= word_in;
      end else begin
        q1_r <= word_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      idle_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        idle_r <= idle_nxt;
      end
    end
  end

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("output queue count out of range");

  a_stop_clears_idle : assert property (@(posedge clk) disable iff (!rst_n)
    push && word_in.stop_scan |=> idle_r == '0)
    else $error("idle count not cleared after stop");

  a_press_clears_idle : assert property (@(posedge clk) disable iff (!rst_n)
    push && word_in.any_pressed |=> idle_r == '0)
    else $error("idle count running while pressed");

  a_reset_needs_press : assert property (@(posedge clk) disable iff (!rst_n)
    push && word_in.reset_event |-> word_in.any_pressed)
    else $error("reset event without a press");

endmodule

// File: rtl/core/button_click_detector.sv
// Channel  | Handshake          | Payload
// input    | in_valid/in_ready  | in_pin_levels (one scan tick)
// result   | out_valid/out_ready| out_first_event .. out_stop_scan
// config   | cfg_we             | cfg_addr, cfg_wdata
//
// One word is taken per cycle; its result is registered in a
// two-word output queue, so in_ready only drops when both queue places are full.
// All lanes and the idle counter update within the accepting cycle.
// Reset (rst_n low, synchronous) loads the register defaults and releases
// all debouncers; no clearing pass is needed.
module button_click_detector import bcd_pkg::*; #(
  parameter int DEBOUNCE_BITS = 4,
  parameter int NUM_BUTTONS   = 2,
  parameter int NUM_PINS      = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIN_W-1:0]  in_pin_levels,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_first_event,
  output logic [3:0]        out_second_event,
  output logic              out_reset_event,
  output logic [2:0]        out_blink_request,
  output logic              out_any_pressed,
  output logic              out_stop_scan,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [PIN_W-1:0]  cfg_wdata
);

  localparam logic [LV_W-1:0] PIN_MASK = LV_W'((64'd1 << NUM_PINS) - 64'd1);

  mode_t              mode_r;
  logic [CNT_W-1:0]   long_r, window_r, hold_r, idle_stop_r;
  logic [PINIX_W-1:0] pin0_r, pin1_r;
  logic [PIN_W-1:0]   rmask_r;

  logic               step, clr;
  logic [LV_W-1:0]    levels, mask;
  lane_res_t          res0, res1;
  hold_res_t          hres;
  word_t              word;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_TOGGLE;
      long_r      <= CNT_W'(50);
      window_r    <= CNT_W'(20);
      hold_r      <= CNT_W'(250);
      idle_stop_r <= CNT_W'(100);
      pin0_r      <= PINIX_W'(0);
      pin1_r      <= PINIX_W'(1);
      rmask_r     <= PIN_W'(3);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_MODE:         mode_r      <= mode_t'(cfg_wdata[1:0]);
        REG_LONG_PRESS:   long_r      <= cfg_wdata[CNT_W-1:0];
        REG_CLICK_WINDOW: window_r    <= cfg_wdata[CNT_W-1:0];
        REG_RESET_HOLD:   hold_r      <= cfg_wdata[CNT_W-1:0];
        REG_IDLE_STOP:    idle_stop_r <= cfg_wdata[CNT_W-1:0];
        REG_FIRST_PIN:    pin0_r      <= cfg_wdata[PINIX_W-1:0];
        REG_SECOND_PIN:   pin1_r      <= cfg_wdata[PINIX_W-1:0];
        REG_RESET_MASK:   rmask_r     <= cfg_wdata;
        default:          mode_r      <= mode_r;
      endcase
    end
  end

  assign clr    = cfg_we && (reg_idx_t'(cfg_addr) == REG_MODE);
  assign step   = in_valid && in_ready;
  assign levels = {{(LV_W-PIN_W){1'b0}}, in_pin_levels} & PIN_MASK;
  assign mask   = {{(LV_W-PIN_W){1'b0}}, rmask_r} & PIN_MASK;

  // Button lanes side by side.
  bcd_lane #(.DEBOUNCE_BITS(DEBOUNCE_BITS), .NUM_PINS(NUM_PINS)) u_lane0 (
    .clk, .rst_n, .step, .clr, .mode(mode_r), .long_ticks(long_r),
    .window_ticks(window_r), .levels, .pin(pin0_r), .res(res0)
  );

  if (NUM_BUTTONS > 1) begin : g_lane1
    bcd_lane #(.DEBOUNCE_BITS(DEBOUNCE_BITS), .NUM_PINS(NUM_PINS)) u_lane1 (
      .clk, .rst_n, .step, .clr, .mode(mode_r), .long_ticks(long_r),
      .window_ticks(window_r), .levels, .pin(pin1_r), .res(res1)
    );
  end else begin : g_no_lane1
    assign res1 = '{ev: EV_NONE, pressed: 1'b0, blink: 1'b0};
  end

  // Reset combination lane.
  bcd_hold #(.DEBOUNCE_BITS(DEBOUNCE_BITS)) u_hold (
    .clk, .rst_n, .step, .hold_ticks(hold_r), .levels, .mask, .res(hres)
  );

  // Merge the lanes into one result word.
  bcd_merge u_merge (
    .clk, .rst_n, .in_valid, .in_ready, .res0, .res1, .hres,
    .idle_stop_ticks(idle_stop_r), .out_valid, .out_ready, .out_word(word)
  );

  assign out_first_event   = word.first_event;
  assign out_second_event  = word.second_event;
  assign out_reset_event   = word.reset_event;
  assign out_blink_request = word.blink_request;
  assign out_any_pressed   = word.any_pressed;
  assign out_stop_scan     = word.stop_scan;

endmodule
